// ===== sv/csfw_pkg.sv =====
// Package for the counting semaphore with FIFO waiters.
// Holds status codes, controller states, command struct and default sizes.
// No dependencies.
package csfw_pkg;

  // Default sizes handed to the top-level parameters
  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int TASK_ID_BITS_DEF = 8;

  // Permit counter limits
  localparam int          PERMIT_BITS  = 8;
  localparam logic [7:0]  PERMIT_MAX   = 8'hFF;
  localparam logic [7:0]  PERMIT_RESET = 8'd1;

  // Request kinds
  localparam logic MODE_ACQUIRE = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  // Result codes
  typedef enum logic [2:0] {
    ST_GRANTED   = 3'd0,
    ST_QUEUED    = 3'd1,
    ST_FULL      = 3'd2,
    ST_IDLE      = 3'd3,
    ST_HANDOFF   = 3'd4,
    ST_SATURATED = 3'd5
  } status_t;

  // Controller states
  typedef enum logic {
    S_WAIT_REQ = 1'b0,
    S_EXEC     = 1'b1
  } ctrl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the incoming request
    logic commit;   // execute the request and load the result register
  } csfw_cmd_t;

endpackage

// ===== sv/csfw_if.sv =====
// Request and result channel interfaces (valid/ready handshake).
// Depends on csfw_pkg.
interface csfw_req_if #(
  parameter int TASK_ID_BITS = csfw_pkg::TASK_ID_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic [TASK_ID_BITS-1:0] task_id;

  modport source (output valid, output mode, output task_id, input ready);
  modport sink   (input valid, input mode, input task_id, output ready);
endinterface

interface csfw_rsp_if #(
  parameter int TASK_ID_BITS = csfw_pkg::TASK_ID_BITS_DEF,
  parameter int QUEUE_DEPTH  = csfw_pkg::QUEUE_DEPTH_DEF
);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic                          valid;
  logic                          ready;
  csfw_pkg::status_t             status;
  logic                          grant_valid;
  logic [TASK_ID_BITS-1:0]       granted_task;
  logic [csfw_pkg::PERMIT_BITS-1:0] permits_now;
  logic [CNT_W-1:0]              waiters_now;

  modport source (output valid, output status, output grant_valid, output granted_task,
                  output permits_now, output waiters_now, input ready);
  modport sink   (input valid, input status, input grant_valid, input granted_task,
                  input permits_now, input waiters_now, output ready);
endinterface

// ===== sv/counting_semaphore_fifo_waiters.sv =====
// Counting semaphore with first-in-first-out hand-off. Each request is an acquire
// (mode 0) or a release (mode 1) with a task id, and yields exactly one result. An
// acquire takes a free permit, else joins the wait queue, else is rejected when the
// queue is full; a release hands its permit to the oldest waiter or raises the count,
// which saturates at 255. Writing cfg_wdata with cfg_we reloads the permit count
// (reset value 1) and keeps the queue. A request is taken in (S_WAIT_REQ) and then
// executed (S_EXEC), with the head waiter from the registered read of the wait-queue
// RAM at the head pointer; execution waits while an earlier result is still unread.
// Depends on csfw_pkg, csfw_if, csfw_ctrl, csfw_dpath and csfw_ram.
module counting_semaphore_fifo_waiters #(
  parameter int QUEUE_DEPTH  = csfw_pkg::QUEUE_DEPTH_DEF,
  parameter int TASK_ID_BITS = csfw_pkg::TASK_ID_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [csfw_pkg::PERMIT_BITS-1:0] cfg_wdata,
  csfw_req_if.sink                         req,
  csfw_rsp_if.source                       rsp
);
  import csfw_pkg::*;

  csfw_cmd_t cmd;

  csfw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  csfw_dpath #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .TASK_ID_BITS (TASK_ID_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_mode      (req.mode),
    .in_task_id   (req.task_id),
    .status       (rsp.status),
    .grant_valid  (rsp.grant_valid),
    .granted_task (rsp.granted_task),
    .permits_now  (rsp.permits_now),
    .waiters_now  (rsp.waiters_now)
  );

endmodule

// ===== sv/csfw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module csfw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/csfw_ctrl.sv =====
// Controller for the semaphore: request handshake, execute step, result valid.
// Depends on csfw_pkg.
module csfw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output csfw_pkg::csfw_cmd_t cmd
);
  import csfw_pkg::*;

  ctrl_state_t state, state_next;
  logic        out_valid_next;

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_WAIT_REQ;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    case (state)
      S_WAIT_REQ: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        // execute only when the result register is free or draining
        if (!out_valid || out_ready) begin
          cmd.commit = 1'b1;
          state_next = S_WAIT_REQ;
        end
      end
      default: state_next = S_WAIT_REQ;
    endcase
  end

  // Result valid: set on commit, cleared when taken
  always_comb begin
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

// ===== sv/csfw_dpath.sv =====
// Datapath: permit counter, wait-queue pointers and count, queue RAM, result register.
// Depends on csfw_pkg and csfw_ram.
module csfw_dpath #(
  parameter int QUEUE_DEPTH  = csfw_pkg::QUEUE_DEPTH_DEF,
  parameter int TASK_ID_BITS = csfw_pkg::TASK_ID_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  csfw_pkg::csfw_cmd_t                 cmd,
  input  logic                                cfg_we,
  input  logic [csfw_pkg::PERMIT_BITS-1:0]    cfg_wdata,
  input  logic                                in_mode,
  input  logic [TASK_ID_BITS-1:0]             in_task_id,
  output csfw_pkg::status_t                   status,
  output logic                                grant_valid,
  output logic [TASK_ID_BITS-1:0]             granted_task,
  output logic [csfw_pkg::PERMIT_BITS-1:0]    permits_now,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]    waiters_now
);
  import csfw_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  logic                    item_mode;
  logic [TASK_ID_BITS-1:0] item_task;
  logic [PERMIT_BITS-1:0]  permit_count, permit_next;
  logic [PTR_W-1:0]        head_pointer, head_next;
  logic [PTR_W-1:0]        tail_pointer, tail_next;
  logic [CNT_W-1:0]        waiter_count, waiter_next;
  logic [TASK_ID_BITS-1:0] head_task;
  logic                    push;
  status_t                 status_next;
  logic                    grant_next;
  logic [TASK_ID_BITS-1:0] granted_next;

  // Latched request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_mode <= in_mode;
      item_task <= in_task_id;
    end
  end

  // Wait queue storage; read port always follows the head
  csfw_ram #(
    .WIDTH (TASK_ID_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (push),
    .waddr (tail_pointer),
    .wdata (item_task),
    .raddr (head_pointer),
    .rdata (head_task)
  );

  // Execute one request
  always_comb begin
    permit_next  = permit_count;
    head_next    = head_pointer;
    tail_next    = tail_pointer;
    waiter_next  = waiter_count;
    push         = 1'b0;
    grant_next   = 1'b0;
    granted_next = '0;
    status_next  = ST_GRANTED;
    if (item_mode == MODE_ACQUIRE) begin
      if (permit_count != '0) begin
        permit_next  = permit_count - 1'b1;
        grant_next   = 1'b1;
        granted_next = item_task;
        status_next  = ST_GRANTED;
      end else if (waiter_count == CNT_FULL) begin
        status_next = ST_FULL;
      end else begin
        push        = cmd.commit;
        tail_next   = (tail_pointer == PTR_LAST) ? '0 : tail_pointer + 1'b1;
        waiter_next = waiter_count + 1'b1;
        status_next = ST_QUEUED;
      end
    end else begin
      if (waiter_count != '0) begin
        // hand the permit to the oldest waiter
        head_next    = (head_pointer == PTR_LAST) ? '0 : head_pointer + 1'b1;
        waiter_next  = waiter_count - 1'b1;
        grant_next   = 1'b1;
        granted_next = head_task;
        status_next  = ST_HANDOFF;
      end else if (permit_count == PERMIT_MAX) begin
        status_next = ST_SATURATED;
      end else begin
        permit_next = permit_count + 1'b1;
        status_next = ST_IDLE;
      end
    end
  end

  // Semaphore state
  always_ff @(posedge clk) begin
    if (rst) begin
      permit_count <= PERMIT_RESET;
      head_pointer <= '0;
      tail_pointer <= '0;
      waiter_count <= '0;
    end else begin
      if (cfg_we) begin
        permit_count <= cfg_wdata;
      end else if (cmd.commit) begin
        permit_count <= permit_next;
      end
      if (cmd.commit) begin
        head_pointer <= head_next;
        tail_pointer <= tail_next;
        waiter_count <= waiter_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status       <= status_next;
      grant_valid  <= grant_next;
      granted_task <= granted_next;
      permits_now  <= permit_next;
      waiters_now  <= waiter_next;
    end
  end

endmodule

// ===== sv/csfw_checker.sv =====
// Port-level checker for the semaphore, bound to the top level.
// Depends on csfw_pkg.
module csfw_checker #(
  parameter int QUEUE_DEPTH  = csfw_pkg::QUEUE_DEPTH_DEF,
  parameter int TASK_ID_BITS = csfw_pkg::TASK_ID_BITS_DEF
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             rsp_valid,
  input logic                             rsp_ready,
  input csfw_pkg::status_t                status,
  input logic                             grant_valid,
  input logic [TASK_ID_BITS-1:0]          granted_task,
  input logic [csfw_pkg::PERMIT_BITS-1:0] permits_now,
  input logic [$clog2(QUEUE_DEPTH+1)-1:0] waiters_now
);
  import csfw_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // A stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(status) && $stable(granted_task)
      && $stable(permits_now) && $stable(waiters_now))
    else $error("result changed while stalled");

  // Grant flag matches the result code, and no task is named without a grant
  a_grant_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (grant_valid == (status == ST_GRANTED || status == ST_HANDOFF))
      && (grant_valid || granted_task == '0))
    else $error("grant flag inconsistent with status");

  // Queueing or rejection only happens with no free permit
  a_no_permit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_QUEUED || status == ST_FULL) |-> permits_now == '0)
    else $error("request waited while permits were free");

  // Rejection means a full queue; queue never exceeds its depth
  a_queue_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (waiters_now <= CNT_W'(QUEUE_DEPTH))
      && (status != ST_FULL || waiters_now == CNT_W'(QUEUE_DEPTH)))
    else $error("wait queue count out of range");

endmodule

bind counting_semaphore_fifo_waiters csfw_checker #(
  .QUEUE_DEPTH  (QUEUE_DEPTH),
  .TASK_ID_BITS (TASK_ID_BITS)
) u_csfw_checker (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .status       (rsp.status),
  .grant_valid  (rsp.grant_valid),
  .granted_task (rsp.granted_task),
  .permits_now  (rsp.permits_now),
  .waiters_now  (rsp.waiters_now)
);

// ===== test/semaphore_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the counting semaphore with FIFO waiters: tracks permits and
// the wait queue, predicts each result and compares it with what the block returns.
// Depends on csfw_pkg and the request/result interfaces in csfw_if.
module semaphore_checker
  import csfw_pkg::*;
#(
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int TASK_ID_BITS = TASK_ID_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [PERMIT_BITS-1:0] cfg_wdata,
  csfw_req_if                    req,
  csfw_rsp_if                    rsp,
  output int                     mismatches,
  output int                     outstanding
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    status_t                 status;
    logic                    grant_valid;
    logic [TASK_ID_BITS-1:0] granted_task;
    logic [PERMIT_BITS-1:0]  permits_now;
    logic [CNT_W-1:0]        waiters_now;
  } outcome_t;

  // Predicted semaphore state
  logic [PERMIT_BITS-1:0]  free_permits;
  logic [TASK_ID_BITS-1:0] waiting_tasks[$];

  // Results still owed by the block, oldest first
  outcome_t expected_outcomes[$];
  outcome_t oldest;

  // Apply one request to the predicted state and return the result it gives
  function automatic outcome_t resolve_request(logic mode, logic [TASK_ID_BITS-1:0] id);
    outcome_t o;
    o = '0;
    if (mode == MODE_ACQUIRE) begin
      if (free_permits != '0) begin
        free_permits   = free_permits - 1'b1;
        o.status       = ST_GRANTED;
        o.grant_valid  = 1'b1;
        o.granted_task = id;
      end else if (waiting_tasks.size() >= QUEUE_DEPTH) begin
        o.status = ST_FULL;
      end else begin
        waiting_tasks.push_back(id);
        o.status = ST_QUEUED;
      end
    end else begin
      // a release goes to the oldest waiter before it counts as a free permit
      if (waiting_tasks.size() > 0) begin
        o.granted_task = waiting_tasks.pop_front();
        o.grant_valid  = 1'b1;
        o.status       = ST_HANDOFF;
      end else if (free_permits == PERMIT_MAX) begin
        o.status = ST_SATURATED;
      end else begin
        free_permits = free_permits + 1'b1;
        o.status     = ST_IDLE;
      end
    end
    o.permits_now = free_permits;
    o.waiters_now = CNT_W'(waiting_tasks.size());
    return o;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      free_permits = PERMIT_RESET;
      waiting_tasks.delete();
      expected_outcomes.delete();
    end else begin
      // compare an accepted result with the oldest prediction
      if (rsp.valid && rsp.ready) begin
        if (expected_outcomes.size() == 0) begin
          $error("result with no request outstanding: status %0d task %0d",
                 rsp.status, rsp.granted_task);
          mismatches++;
        end else begin
          oldest = expected_outcomes.pop_front();
          if (rsp.status !== oldest.status) begin
            $error("status: expected %0d, got %0d", oldest.status, rsp.status);
            mismatches++;
          end
          if (rsp.grant_valid !== oldest.grant_valid) begin
            $error("grant_valid: expected %0d, got %0d", oldest.grant_valid,
                   rsp.grant_valid);
            mismatches++;
          end
          if (rsp.granted_task !== oldest.granted_task) begin
            $error("granted_task: expected %0d, got %0d", oldest.granted_task,
                   rsp.granted_task);
            mismatches++;
          end
          if (rsp.permits_now !== oldest.permits_now) begin
            $error("permits_now: expected %0d, got %0d", oldest.permits_now,
                   rsp.permits_now);
            mismatches++;
          end
          if (rsp.waiters_now !== oldest.waiters_now) begin
            $error("waiters_now: expected %0d, got %0d", oldest.waiters_now,
                   rsp.waiters_now);
            mismatches++;
          end
        end
      end
      // register write reloads the count, the queue stays
      if (cfg_we) free_permits = cfg_wdata;
      if (req.valid && req.ready)
        expected_outcomes.push_back(resolve_request(req.mode, req.task_id));
    end
    outstanding <= expected_outcomes.size();
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for counting_semaphore_fifo_waiters: drives requests, result-side
// stalls and permit reloads, and gives the verdict from the checker's count.
// Depends on csfw_pkg, csfw_if, the block and semaphore_checker.
module tb;
  import csfw_pkg::*;

  localparam int QUEUE_DEPTH  = QUEUE_DEPTH_DEF;
  localparam int TASK_ID_BITS = TASK_ID_BITS_DEF;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 193;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [PERMIT_BITS-1:0] cfg_wdata = '0;
  logic                   rsp_ready_q = 1'b0;
  logic                   rsp_no_stall = 1'b0;
  logic                   send_calm = 1'b0;
  int                     stall_left;
  int                     cycle_count;
  int                     mismatches;
  int                     outstanding;

  csfw_req_if #(.TASK_ID_BITS(TASK_ID_BITS)) req_ch ();
  csfw_rsp_if #(.TASK_ID_BITS(TASK_ID_BITS), .QUEUE_DEPTH(QUEUE_DEPTH)) rsp_ch ();

  assign rsp_ch.ready = rsp_ready_q;

  counting_semaphore_fifo_waiters #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TASK_ID_BITS(TASK_ID_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  semaphore_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TASK_ID_BITS(TASK_ID_BITS)
  ) checker_i (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // mostly no gap, some short ones, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  // Result-side stalls
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready_q <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_ready_q <= 1'b0;
    end else if (!rsp_no_stall && $urandom_range(0, 2) == 0) begin
      stall_left = gap_len();
      rsp_ready_q <= (stall_left == 0);
    end else begin
      rsp_ready_q <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("counting_semaphore_fifo_waiters regression: fail");
      $finish;
    end
  end

  // Offer one request, hold it until taken, then maybe leave a gap
  task automatic send_request(input logic mode, input logic [TASK_ID_BITS-1:0] id);
    int gap;
    req_ch.valid   <= 1'b1;
    req_ch.mode    <= mode;
    req_ch.task_id <= id;
    do @(posedge clk); while (!req_ch.ready);
    gap = send_calm ? 0 : gap_len();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and let every owed result come back
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_permits(input logic [PERMIT_BITS-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [PERMIT_BITS-1:0] permits_sel;
    int                     acq_pct;
    req_ch.valid   <= 1'b0;
    req_ch.mode    <= MODE_ACQUIRE;
    req_ch.task_id <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset count of one, then saturation at the top of the count
    send_request(MODE_ACQUIRE, 8'hC3);
    load_permits(PERMIT_MAX);
    send_request(MODE_RELEASE, 8'h00);
    send_request(MODE_ACQUIRE, 8'hFF);
    send_request(MODE_RELEASE, 8'h5A);

    // no permits: fill the wait queue, then one more is rejected
    load_permits(8'd0);
    for (int i = 0; i < QUEUE_DEPTH; i++)
      send_request(MODE_ACQUIRE, TASK_ID_BITS'(i * 17));
    send_request(MODE_ACQUIRE, 8'h3C);

    // reload with waiters kept: acquire takes a free permit, release hands off
    load_permits(PERMIT_MAX);
    send_request(MODE_ACQUIRE, 8'h81);
    send_request(MODE_RELEASE, 8'h7E);

    // Random phases, each with its own permit load and acquire/release mix
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin permits_sel = 8'd0;   acq_pct = 75; end
        1: begin permits_sel = 8'd1;   acq_pct = 60; end
        2: begin permits_sel = 8'd255; acq_pct = 35; end
        3: begin permits_sel = 8'd2;   acq_pct = 55; end
        4: begin permits_sel = 8'd254; acq_pct = 40; end
        5: begin permits_sel = 8'd0;   acq_pct = 85; end
        7: begin permits_sel = 8'd3;   acq_pct = 65; end
        8: begin permits_sel = 8'd255; acq_pct = 25; end
        default: begin
          permits_sel = PERMIT_BITS'($urandom_range(0, 255));
          acq_pct     = 50;
        end
      endcase
      load_permits(permits_sel);
      send_calm    <= (ph % 4 == 3);
      rsp_no_stall <= (ph % 5 == 2);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // hold off mid-phase until the block has answered everything
        if (k == PHASE_ITEMS / 2 && ph % 3 == 0) wait_idle();
        send_request(($urandom_range(0, 99) < acq_pct) ? MODE_ACQUIRE : MODE_RELEASE,
                     TASK_ID_BITS'($urandom_range(0, 255)));
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("counting_semaphore_fifo_waiters regression: pass");
    end else begin
      $display("counting_semaphore_fifo_waiters regression: fail");
    end
    $finish;
  end

endmodule
